FILE: rtl/lovm_pkg.sv
`timescale 1ns / 1ps

package lovm_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int LW         = FRAC_BITS + 2;   // normalized vector component
    localparam int QW         = FRAC_BITS + 1;   // quotient magnitude
    localparam int NW         = 32 + FRAC_BITS;  // dividend magnitude
    localparam int MW         = 33;              // multiplier operand
    localparam int EYE_W      = 27;
    localparam int VLIM_W     = 17;
    localparam int EW         = EYE_W + 2;       // eye position component
    localparam int DOTW       = EYE_W + 4;       // eye dot products
    localparam int SQRT_STEPS = 32;
    localparam int ITER_W     = $clog2(SQRT_STEPS);

    localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);
    // squared length bound equal to a length of 1e-5
    localparam logic [63:0] TINY_SQ =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd9999999999) / 64'd10000000000;

    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_in;

    typedef struct packed {
        logic [1:0]         column_index;
        logic signed [31:0] elem_row0;
        logic signed [31:0] elem_row1;
        logic signed [31:0] elem_row2;
        logic signed [31:0] elem_row3;
        logic               matrix_changed;
        logic               last_column;
    } t_out;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } t_ds_ctl;

endpackage

FILE: rtl/lovm_mul.sv
`timescale 1ns / 1ps

module lovm_mul (
    input  logic                              i_clk,
    input  logic signed [lovm_pkg::MW-1:0]    i_a,
    input  logic signed [lovm_pkg::MW-1:0]    i_b,
    output logic signed [63:0]                o_p
);
    import lovm_pkg::*;

    logic signed [2*MW-1:0] w_prod;
    logic signed [63:0]     r_p;

    assign w_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= w_prod[63:0];
    end

    assign o_p = r_p;

endmodule

FILE: rtl/lovm_divsqrt.sv
`timescale 1ns / 1ps

module lovm_divsqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lovm_pkg::t_ds_ctl                 i_ctl,
    input  logic [63:0]                       i_rad,
    input  logic signed [31:0]                i_num,
    input  logic [31:0]                       i_den,
    output logic                              o_done,
    output logic [31:0]                       o_root,
    output logic signed [lovm_pkg::LW-1:0]    o_quo
);
    import lovm_pkg::*;

    logic              r_busy;
    logic              r_sqrt;
    logic              r_done;
    logic [ITER_W-1:0] r_cnt;
    logic [63:0]       r_v;
    logic [63:0]       r_res;
    logic [63:0]       r_bit;
    logic [NW-1:0]     r_rem;
    logic [NW-1:0]     r_dsh;
    logic [QW-1:0]     r_q;
    logic              r_neg;

    logic [63:0]       w_trial;
    logic [31:0]       w_mag;

    assign w_trial = r_res + r_bit;
    assign w_mag   = i_num[31] ? (~i_num + 32'd1) : i_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_ctl.is_sqrt;
                r_cnt  <= i_ctl.is_sqrt ? ITER_W'(SQRT_STEPS - 1) : ITER_W'(QW - 1);
                r_v    <= i_rad;
                r_res  <= '0;
                r_bit  <= 64'd1 << 62;
                r_rem  <= {w_mag, {FRAC_BITS{1'b0}}};
                r_dsh  <= {i_den, {FRAC_BITS{1'b0}}};
                r_q    <= '0;
                r_neg  <= i_num[31];
            end else if (r_busy) begin
                if (r_sqrt) begin
                    if (r_v >= w_trial) begin
                        r_v   <= r_v - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    // restoring step, one quotient bit
                    if (r_rem >= r_dsh) begin
                        r_rem <= r_rem - r_dsh;
                        r_q   <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[QW-2:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];
    assign o_quo  = r_neg ? (LW'(0) - LW'(r_q)) : LW'(r_q);

endmodule

FILE: rtl/light_ortho_view_matrix_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// input     in         i_valid / o_stall      i_data   (t_in)
// output    out        o_valid / i_stall      o_data   (t_out, one column per item)
// config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// one item runs 24 multiply-accumulate steps on the shared multiplier, 2 square roots and
// 6 divisions on the shared iterative unit, then 4 column items; fewer steps when the
// direction is degenerate
// synchronous active-low reset: matrix to identity, registers to their defaults
// a stalled output holds its column; the next item is taken while it waits

module light_ortho_view_matrix_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  lovm_pkg::t_in                  i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output lovm_pkg::t_out                 o_data,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_index,
    input  logic [lovm_pkg::EYE_W-1:0]     i_cfg_data
);
    import lovm_pkg::*;

    localparam int PC_W = 6;
    localparam logic [0:0] CFG_EYE  = 1'b0;
    localparam logic [0:0] CFG_VLIM = 1'b1;
    localparam logic [EYE_W-1:0]  EYE_RST  = EYE_W'(19660800);
    localparam logic [VLIM_W-1:0] VLIM_RST = VLIM_W'(64225);
    localparam int WIDTH_SH = 7;
    localparam int DEPTH_SH = 8;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_OUT} t_state;
    typedef enum logic [2:0] {OP_MAC, OP_CHK, OP_SQRT, OP_DIV, OP_VSEL, OP_COMMIT} t_op;
    typedef enum logic [3:0] {
        SRC_D0, SRC_D1, SRC_D2, SRC_L0, SRC_L1, SRC_L2, SRC_R0, SRC_R1,
        SRC_R2, SRC_U0, SRC_U1, SRC_U2, SRC_E0, SRC_E1, SRC_E2, SRC_EYE
    } t_src;
    typedef enum logic [4:0] {
        DST_NONE, DST_SQ, DST_DEN, DST_L0, DST_L1, DST_L2, DST_R0, DST_R1, DST_R2,
        DST_U0, DST_U1, DST_U2, DST_E0, DST_E1, DST_E2, DST_RE, DST_UE, DST_LE
    } t_dst;
    typedef struct packed {
        t_op  op;
        t_src a;
        t_src b;
        logic neg;
        logic first;
        logic last;
        t_dst dst;
    } t_uop;

    function automatic t_uop mk(input t_op op, input t_src a, input t_src b,
                                input logic neg, input logic first, input logic last,
                                input t_dst dst);
        t_uop u;
        u.op = op; u.a = a; u.b = b; u.neg = neg;
        u.first = first; u.last = last; u.dst = dst;
        return u;
    endfunction

    function automatic t_uop prog(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = mk(OP_MAC, SRC_D0, SRC_D0, 1'b0, 1'b1, 1'b0, DST_NONE);
            6'd1:  u = mk(OP_MAC, SRC_D1, SRC_D1, 1'b0, 1'b0, 1'b0, DST_NONE);
            6'd2:  u = mk(OP_MAC, SRC_D2, SRC_D2, 1'b0, 1'b0, 1'b1, DST_SQ);
            6'd3:  u = mk(OP_CHK, SRC_D0, SRC_D0, 1'b0, 1'b0, 1'b0, DST_NONE);
            6'd4:  u = mk(OP_SQRT, SRC_D0, SRC_D0, 1'b0, 1'b0, 1'b0, DST_DEN);
            6'd5:  u = mk(OP_DIV, SRC_D0, SRC_D0, 1'b0, 1'b0, 1'b0, DST_L0);
            6'd6:  u = mk(OP_DIV, SRC_D1, SRC_D1, 1'b0, 1'b0, 1'b0, DST_L1);
            6'd7:  u = mk(OP_DIV, SRC_D2, SRC_D2, 1'b0, 1'b0, 1'b0, DST_L2);
            6'd8:  u = mk(OP_VSEL, SRC_L1, SRC_L1, 1'b0, 1'b0, 1'b0, DST_NONE);
            6'd9:  u = mk(OP_MAC, SRC_R0, SRC_R0, 1'b0, 1'b1, 1'b0, DST_NONE);
            6'd10: u = mk(OP_MAC, SRC_R1, SRC_R1, 1'b0, 1'b0, 1'b0, DST_NONE);
            6'd11: u = mk(OP_MAC, SRC_R2, SRC_R2, 1'b0, 1'b0, 1'b1, DST_SQ);
            6'd12: u = mk(OP_CHK, SRC_D0, SRC_D0, 1'b0, 1'b0, 1'b0, DST_NONE);
            6'd13: u = mk(OP_SQRT, SRC_D0, SRC_D0, 1'b0, 1'b0, 1'b0, DST_DEN);
            6'd14: u = mk(OP_DIV, SRC_R0, SRC_R0, 1'b0, 1'b0, 1'b0, DST_R0);
            6'd15: u = mk(OP_DIV, SRC_R1, SRC_R1, 1'b0, 1'b0, 1'b0, DST_R1);
            6'd16: u = mk(OP_DIV, SRC_R2, SRC_R2, 1'b0, 1'b0, 1'b0, DST_R2);
            // up = right x forward, forward = -direction
            6'd17: u = mk(OP_MAC, SRC_R2, SRC_L1, 1'b0, 1'b1, 1'b0, DST_NONE);
            6'd18: u = mk(OP_MAC, SRC_R1, SRC_L2, 1'b1, 1'b0, 1'b1, DST_U0);
            6'd19: u = mk(OP_MAC, SRC_R0, SRC_L2, 1'b0, 1'b1, 1'b0, DST_NONE);
            6'd20: u = mk(OP_MAC, SRC_R2, SRC_L0, 1'b1, 1'b0, 1'b1, DST_U1);
            6'd21: u = mk(OP_MAC, SRC_R1, SRC_L0, 1'b0, 1'b1, 1'b0, DST_NONE);
            6'd22: u = mk(OP_MAC, SRC_R0, SRC_L1, 1'b1, 1'b0, 1'b1, DST_U2);
            6'd23: u = mk(OP_MAC, SRC_L0, SRC_EYE, 1'b0, 1'b1, 1'b1, DST_E0);
            6'd24: u = mk(OP_MAC, SRC_L1, SRC_EYE, 1'b0, 1'b1, 1'b1, DST_E1);
            6'd25: u = mk(OP_MAC, SRC_L2, SRC_EYE, 1'b0, 1'b1, 1'b1, DST_E2);
            6'd26: u = mk(OP_MAC, SRC_R0, SRC_E0, 1'b0, 1'b1, 1'b0, DST_NONE);
            6'd27: u = mk(OP_MAC, SRC_R1, SRC_E1, 1'b0, 1'b0, 1'b0, DST_NONE);
            6'd28: u = mk(OP_MAC, SRC_R2, SRC_E2, 1'b0, 1'b0, 1'b1, DST_RE);
            6'd29: u = mk(OP_MAC, SRC_U0, SRC_E0, 1'b0, 1'b1, 1'b0, DST_NONE);
            6'd30: u = mk(OP_MAC, SRC_U1, SRC_E1, 1'b0, 1'b0, 1'b0, DST_NONE);
            6'd31: u = mk(OP_MAC, SRC_U2, SRC_E2, 1'b0, 1'b0, 1'b1, DST_UE);
            6'd32: u = mk(OP_MAC, SRC_L0, SRC_E0, 1'b0, 1'b1, 1'b0, DST_NONE);
            6'd33: u = mk(OP_MAC, SRC_L1, SRC_E1, 1'b0, 1'b0, 1'b0, DST_NONE);
            6'd34: u = mk(OP_MAC, SRC_L2, SRC_E2, 1'b0, 1'b0, 1'b1, DST_LE);
            default: u = mk(OP_COMMIT, SRC_D0, SRC_D0, 1'b0, 1'b0, 1'b0, DST_NONE);
        endcase
        return u;
    endfunction

    // divide by 2^sh, rounding toward zero
    function automatic logic signed [63:0] shr0(input logic signed [63:0] x, input int sh);
        logic signed [63:0] bias;
        bias = x[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
        return (x + bias) >>> sh;
    endfunction

    // same, keeping the low 32 bits
    function automatic logic signed [31:0] shr32(input logic signed [63:0] x, input int sh);
        logic signed [63:0] q;
        q = shr0(x, sh);
        return q[31:0];
    endfunction

    t_state               r_state;
    logic [PC_W-1:0]      r_pc;
    logic                 r_ph;
    logic [1:0]           r_col;
    logic                 r_changed;
    logic                 r_ovalid;
    t_out                 r_out;
    logic [EYE_W-1:0]     r_eye;
    logic [VLIM_W-1:0]    r_vlim;
    logic signed [31:0]   r_mat [16];
    logic signed [31:0]   r_d [3];
    logic signed [LW-1:0] r_l [3];
    logic signed [LW-1:0] r_r [3];
    logic signed [LW-1:0] r_u [3];
    logic signed [EW-1:0] r_e [3];
    logic signed [DOTW-1:0] r_re;
    logic signed [DOTW-1:0] r_ue;
    logic signed [DOTW-1:0] r_le;
    logic [63:0]          r_sq;
    logic [31:0]          r_den;
    logic signed [63:0]   r_acc;

    t_uop                 w_uop;
    logic signed [MW-1:0] w_opnd [16];
    logic signed [MW-1:0] w_mul_a;
    logic signed [MW-1:0] w_mul_b;
    logic signed [63:0]   w_p;
    logic signed [63:0]   w_acc;
    logic signed [63:0]   w_trunc;
    logic [LW-1:0]        w_abs_l1;
    logic                 w_out_free;
    t_out                 w_col;
    t_ds_ctl              w_ds_ctl;
    logic                 w_ds_done;
    logic [31:0]          w_root;
    logic signed [LW-1:0] w_quo;

    assign w_uop = prog(r_pc);

    always_comb begin
        w_opnd[SRC_D0]  = MW'(r_d[0]);
        w_opnd[SRC_D1]  = MW'(r_d[1]);
        w_opnd[SRC_D2]  = MW'(r_d[2]);
        w_opnd[SRC_L0]  = MW'(r_l[0]);
        w_opnd[SRC_L1]  = MW'(r_l[1]);
        w_opnd[SRC_L2]  = MW'(r_l[2]);
        w_opnd[SRC_R0]  = MW'(r_r[0]);
        w_opnd[SRC_R1]  = MW'(r_r[1]);
        w_opnd[SRC_R2]  = MW'(r_r[2]);
        w_opnd[SRC_U0]  = MW'(r_u[0]);
        w_opnd[SRC_U1]  = MW'(r_u[1]);
        w_opnd[SRC_U2]  = MW'(r_u[2]);
        w_opnd[SRC_E0]  = MW'(r_e[0]);
        w_opnd[SRC_E1]  = MW'(r_e[1]);
        w_opnd[SRC_E2]  = MW'(r_e[2]);
        w_opnd[SRC_EYE] = MW'(r_eye);
    end

    assign w_mul_a = w_opnd[w_uop.a];
    assign w_mul_b = w_opnd[w_uop.b];

    lovm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    assign w_ds_ctl.start   = (r_state == ST_RUN) &&
                              ((w_uop.op == OP_SQRT) || (w_uop.op == OP_DIV));
    assign w_ds_ctl.is_sqrt = (w_uop.op == OP_SQRT);

    lovm_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ds_ctl),
        .i_rad   (r_sq),
        .i_num   (w_mul_a[31:0]),
        .i_den   (r_den),
        .o_done  (w_ds_done),
        .o_root  (w_root),
        .o_quo   (w_quo)
    );

    assign w_acc    = (w_uop.first ? 64'sd0 : r_acc) + (w_uop.neg ? -w_p : w_p);
    assign w_trunc  = shr0(w_acc, FRAC_BITS);
    assign w_abs_l1 = r_l[1][LW-1] ? (LW'(0) - r_l[1]) : r_l[1];
    assign w_out_free = !r_ovalid || !i_stall;

    always_comb begin
        w_col.column_index   = r_col;
        w_col.elem_row0      = r_mat[{r_col, 2'd0}];
        w_col.elem_row1      = r_mat[{r_col, 2'd1}];
        w_col.elem_row2      = r_mat[{r_col, 2'd2}];
        w_col.elem_row3      = r_mat[{r_col, 2'd3}];
        w_col.matrix_changed = r_changed;
        w_col.last_column    = (r_col == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pc      <= '0;
            r_ph      <= 1'b0;
            r_col     <= '0;
            r_changed <= 1'b0;
            r_ovalid  <= 1'b0;
            r_eye     <= EYE_RST;
            r_vlim    <= VLIM_RST;
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= ((i % 5) == 0) ? ONE_Q : 32'sd0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EYE:  r_eye  <= i_cfg_data;
                    CFG_VLIM: r_vlim <= i_cfg_data[VLIM_W-1:0];
                    default:  ;
                endcase
            end
            // in the output state the column load below owns the valid flag
            if (r_ovalid && !i_stall && (r_state != ST_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_d[0]  <= i_data.dir_x;
                        r_d[1]  <= i_data.dir_y;
                        r_d[2]  <= i_data.dir_z;
                        r_pc    <= '0;
                        r_ph    <= 1'b0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    case (w_uop.op)
                        OP_MAC: begin
                            if (!r_ph) begin
                                r_ph <= 1'b1;
                            end else begin
                                r_ph  <= 1'b0;
                                r_acc <= w_acc;
                                r_pc  <= r_pc + 1'b1;
                                if (w_uop.last) begin
                                    case (w_uop.dst)
                                        DST_SQ: r_sq   <= w_acc;
                                        DST_U0: r_u[0] <= w_trunc[LW-1:0];
                                        DST_U1: r_u[1] <= w_trunc[LW-1:0];
                                        DST_U2: r_u[2] <= w_trunc[LW-1:0];
                                        DST_E0: r_e[0] <= w_trunc[EW-1:0];
                                        DST_E1: r_e[1] <= w_trunc[EW-1:0];
                                        DST_E2: r_e[2] <= w_trunc[EW-1:0];
                                        DST_RE: r_re   <= w_trunc[DOTW-1:0];
                                        DST_UE: r_ue   <= w_trunc[DOTW-1:0];
                                        DST_LE: r_le   <= w_trunc[DOTW-1:0];
                                        default: ;
                                    endcase
                                end
                            end
                        end
                        OP_CHK: begin
                            if (r_sq < TINY_SQ) begin
                                // degenerate vector, keep the stored matrix
                                r_changed <= 1'b0;
                                r_col     <= '0;
                                r_state   <= ST_OUT;
                            end else begin
                                r_pc <= r_pc + 1'b1;
                            end
                        end
                        OP_SQRT, OP_DIV: begin
                            r_state <= ST_WAIT;
                        end
                        OP_VSEL: begin
                            // near-vertical direction takes X as up
                            if (32'(w_abs_l1) > 32'(r_vlim)) begin
                                r_r[0] <= '0;
                                r_r[1] <= LW'(0) - r_l[2];
                                r_r[2] <= r_l[1];
                            end else begin
                                r_r[0] <= r_l[2];
                                r_r[1] <= '0;
                                r_r[2] <= LW'(0) - r_l[0];
                            end
                            r_pc <= r_pc + 1'b1;
                        end
                        default: begin
                            for (int c = 0; c < 3; c++) begin
                                r_mat[c*4+0] <= shr32(64'(r_r[c]), WIDTH_SH);
                                r_mat[c*4+1] <= shr32(64'(r_u[c]), WIDTH_SH);
                                r_mat[c*4+2] <= shr32(64'sd0 - 64'(r_l[c]), DEPTH_SH);
                                r_mat[c*4+3] <= 32'sd0;
                            end
                            r_mat[12]  <= shr32(64'sd0 - 64'(r_re), WIDTH_SH);
                            r_mat[13]  <= shr32(64'sd0 - 64'(r_ue), WIDTH_SH);
                            r_mat[14]  <= shr32(64'(r_le), DEPTH_SH);
                            r_mat[15]  <= ONE_Q;
                            r_changed  <= 1'b1;
                            r_col      <= '0;
                            r_state    <= ST_OUT;
                        end
                    endcase
                end
                ST_WAIT: begin
                    if (w_ds_done) begin
                        case (w_uop.dst)
                            DST_DEN: r_den  <= w_root;
                            DST_L0:  r_l[0] <= w_quo;
                            DST_L1:  r_l[1] <= w_quo;
                            DST_L2:  r_l[2] <= w_quo;
                            DST_R0:  r_r[0] <= w_quo;
                            DST_R1:  r_r[1] <= w_quo;
                            DST_R2:  r_r[2] <= w_quo;
                            default: ;
                        endcase
                        r_pc    <= r_pc + 1'b1;
                        r_state <= ST_RUN;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out    <= w_col;
                        r_ovalid <= 1'b1;
                        r_col    <= r_col + 1'b1;
                        if (r_col == 2'd3) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_column == (o_data.column_index == 2'd3)))
        else $error("last_column flag disagrees with column index");

    a_ds_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ds_done |-> (r_state == ST_WAIT))
        else $error("div/sqrt result arrived outside wait state");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> ((r_state == ST_RUN) && (r_pc == '0)))
        else $error("accepted item did not start the program");

    a_corner_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mat[15] == ONE_Q)
        else $error("matrix corner element lost its unit value");
`endif

endmodule
